@@ rtl/sha1_message_hasher_defines.svh @@
// ---------------------------------------------------------------------------
// sha1 hasher assertion macros
// shared assertion helpers for the hasher rtl
// ---------------------------------------------------------------------------
`ifndef SHA1_MESSAGE_HASHER_DEFINES_SVH
`define SHA1_MESSAGE_HASHER_DEFINES_SVH
`ifndef ASSERT_OFF
`define SHA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SHA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SHA_ASSERT_IMP(label, clk, rst, ante, cons)
`define SHA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/sha1_pkg.sv @@
// ---------------------------------------------------------------------------
// sha1 package
// constants, payload types and round helpers
// ---------------------------------------------------------------------------
package sha1_pkg;

  localparam int WORDS = 5;
  localparam int WIN = 16;
  localparam int ROUNDS = 80;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       has_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  typedef logic [31:0] word_t;

  localparam word_t H_INIT [WORDS] = '{32'h67452301, 32'hefcdab89, 32'h98badcfe,
                                       32'h10325476, 32'hc3d2e1f0};
  localparam word_t K_CONST [4] = '{32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc,
                                    32'hca62c1d6};
  localparam logic [7:0] PAD_BYTE = 8'h80;

  function automatic word_t round_f(input logic [1:0] stage, input word_t x,
                                    input word_t y, input word_t z);
    word_t r;
    case (stage)
      2'd0:    r = (x & y) | (~x & z);
      2'd2:    r = (x & y) | (x & z) | (y & z);
      default: r = x ^ y ^ z;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/sha1_stream_if.sv @@
// ---------------------------------------------------------------------------
// sha1 stream interface
// valid/ready channel carrying one payload item
// ---------------------------------------------------------------------------
interface sha1_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/sha1_round_unit.sv @@
// ---------------------------------------------------------------------------
// sha1 round unit
// one shared round: schedule word and working register update
// ---------------------------------------------------------------------------
module sha1_round_unit (
  input  logic [6:0]          round,
  input  sha1_pkg::word_t     w_in [16],
  input  sha1_pkg::word_t     work_in [5],
  output sha1_pkg::word_t     w_new,
  output sha1_pkg::word_t     work_out [5]
);
  import sha1_pkg::*;

  logic [3:0] t;
  logic [1:0] stage;
  word_t      x;
  word_t      tmp;

  assign t = round[3:0];
  assign stage = (round < 7'd20) ? 2'd0 : (round < 7'd40) ? 2'd1 :
                 (round < 7'd60) ? 2'd2 : 2'd3;

  always_comb begin
    x = w_in[t - 4'd3] ^ w_in[t - 4'd8] ^ w_in[t - 4'd14] ^ w_in[t];
    w_new = (round < 7'd16) ? w_in[t] : {x[30:0], x[31]};
    tmp = {work_in[0][26:0], work_in[0][31:27]}
          + round_f(stage, work_in[1], work_in[2], work_in[3])
          + work_in[4] + K_CONST[stage] + w_new;
    work_out[0] = tmp;
    work_out[1] = work_in[0];
    work_out[2] = {work_in[1][1:0], work_in[1][31:2]};
    work_out[3] = work_in[2];
    work_out[4] = work_in[3];
  end
endmodule

@@ rtl/sha1_message_hasher.sv @@
// ---------------------------------------------------------------------------
// sha1 message hasher
// byte-stream sha-1 with padding and five-word digest output
// ---------------------------------------------------------------------------
// usage: in_ch carries one item per handshake: msg_byte, has_byte and
// end_of_message. out_ch carries the digest as five items, H0 first,
// word_index 0..4, last_word set on the fifth.
// a byte item is written into the schedule window; the 64th byte of a
// block starts 80 compression rounds, one per cycle through the shared
// round unit, then a fold into the chaining words. the final item walks
// the padding one byte a cycle, writes the length into the last two
// window words and compresses (the padding may span two blocks).
// the five digest items are read from the chaining registers; while the
// receiver stalls the block holds, and in_ch is not ready until the
// digest has been taken, after which all state is back at its initial
// values. synchronous reset restores the initial chaining words and
// clears fill, length and the schedule window.
// ---------------------------------------------------------------------------
`include "sha1_message_hasher_defines.svh"
module sha1_message_hasher (
  input  logic clk,
  input  logic rst,
  sha1_stream_if.sink   in_ch,
  sha1_stream_if.source out_ch
);
  import sha1_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ROUND = 3'd1;
  localparam logic [2:0] S_FOLD = 3'd2;
  localparam logic [2:0] S_PAD = 3'd3;
  localparam logic [2:0] S_OUT = 3'd4;

  logic [2:0]  state;
  logic [6:0]  round;
  logic [5:0]  fill;
  logic [63:0] bit_count;
  logic        finishing;
  logic        padded;
  logic [2:0]  out_idx;
  word_t       chain [5];
  word_t       work [5];
  word_t       win [16];
  word_t       w_new;
  word_t       work_rnd [5];

  sha1_round_unit u_round (
    .round(round), .w_in(win), .work_in(work), .w_new(w_new), .work_out(work_rnd)
  );

  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.data.digest_word = chain[out_idx];
  assign out_ch.data.word_index = out_idx;
  assign out_ch.data.last_word = (out_idx == 3'd4);

  // pad byte: 0x80 first, then zeros; the length goes in at fill 56
  logic [7:0] byte_in;
  logic       do_byte;
  logic       pad_len;
  assign pad_len = (state == S_PAD) && padded && (fill == 6'd56);
  always_comb begin
    do_byte = 1'b0;
    byte_in = 8'h00;
    if (state == S_IDLE && in_ch.valid && in_ch.data.has_byte) begin
      do_byte = 1'b1;
      byte_in = in_ch.data.msg_byte;
    end else if (state == S_PAD && !pad_len) begin
      do_byte = 1'b1;
      byte_in = padded ? 8'h00 : PAD_BYTE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      round <= '0;
      fill <= '0;
      bit_count <= '0;
      finishing <= 1'b0;
      padded <= 1'b0;
      out_idx <= '0;
      for (int i = 0; i < 5; i++) chain[i] <= H_INIT[i];
      for (int i = 0; i < 5; i++) work[i] <= '0;
      for (int i = 0; i < 16; i++) win[i] <= '0;
    end else begin
      if (do_byte) begin
        win[fill[5:2]][8*(3-fill[1:0]) +: 8] <= byte_in;
        fill <= fill + 6'd1;
      end
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            if (in_ch.data.has_byte) bit_count <= bit_count + 64'd8;
            finishing <= in_ch.data.end_of_message;
            if (in_ch.data.has_byte && fill == 6'd63) begin
              state <= S_ROUND;
              for (int i = 0; i < 5; i++) work[i] <= chain[i];
            end else if (in_ch.data.end_of_message) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          if (pad_len) begin
            win[14] <= bit_count[63:32];
            win[15] <= bit_count[31:0];
            fill <= '0;
            finishing <= 1'b0;
            state <= S_ROUND;
            for (int i = 0; i < 5; i++) work[i] <= chain[i];
          end else begin
            padded <= 1'b1;
            if (fill == 6'd63) begin
              state <= S_ROUND;
              for (int i = 0; i < 5; i++) work[i] <= chain[i];
            end
          end
        end
        S_ROUND: begin
          win[round[3:0]] <= w_new;
          for (int i = 0; i < 5; i++) work[i] <= work_rnd[i];
          if (round == 7'(ROUNDS - 1)) begin
            round <= '0;
            state <= S_FOLD;
          end else begin
            round <= round + 7'd1;
          end
        end
        S_FOLD: begin
          for (int i = 0; i < 5; i++) chain[i] <= chain[i] + work[i];
          for (int i = 0; i < 16; i++) win[i] <= '0;
          if (finishing) state <= S_PAD;
          else if (padded) state <= S_OUT;
          else state <= S_IDLE;
        end
        S_OUT: begin
          if (out_ch.ready) begin
            if (out_idx == 3'd4) begin
              out_idx <= '0;
              state <= S_IDLE;
              bit_count <= '0;
              padded <= 1'b0;
              for (int i = 0; i < 5; i++) chain[i] <= H_INIT[i];
              for (int i = 0; i < 5; i++) work[i] <= '0;
            end else begin
              out_idx <= out_idx + 3'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SHA_ASSERT_IMP(a_ready_only_idle, clk, rst, in_ch.ready, !out_ch.valid)
  `SHA_ASSERT_IMP(a_round_range, clk, rst, state == S_ROUND, round < 7'(ROUNDS))
  `SHA_ASSERT_NEXT(a_last_to_idle, clk, rst,
    out_ch.valid && out_ch.ready && out_ch.data.last_word, in_ch.ready && fill == 6'd0)
  `SHA_ASSERT_IMP(a_idx_range, clk, rst, out_ch.valid, out_idx <= 3'd4)
endmodule

@@ tb/sv/tb.sv @@
// ---------------------------------------------------------------------------
// sha1 message hasher testbench
// drives byte-stream messages, predicts each five-word sha-1 digest and
// compares every digest item in order
// ---------------------------------------------------------------------------
module tb;
  import sha1_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sha1_stream_if #(.payload_t(in_item_t))  in_ch ();
  sha1_stream_if #(.payload_t(out_item_t)) out_ch ();

  sha1_message_hasher dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  always #6 clk = ~clk;

  // predictor state
  word_t       chain [WORDS];
  word_t       sched [WIN];
  logic [5:0]  fill;
  logic [63:0] bit_len;

  in_item_t  pending_items [$];
  out_item_t digest_queue [$];
  int        send_idle_pct = 37;
  int        recv_idle_pct = 60;
  int        hold_off = 0;
  int        errors = 0;
  int        cycles = 0;
  bit        stim_done = 1'b0;

  function automatic word_t rotl(word_t v, int k);
    return (v << k) | (v >> (32 - k));
  endfunction

  function automatic void sha1_compress();
    word_t a, b, c, d, e, w, t;
    logic [1:0] stage;
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
    for (int r = 0; r < ROUNDS; r++) begin
      stage = 2'(r / 20);
      if (r >= 16) begin
        w = rotl(sched[(r - 3) & 15] ^ sched[(r - 8) & 15] ^ sched[(r - 14) & 15]
                 ^ sched[r & 15], 1);
        sched[r & 15] = w;
      end else begin
        w = sched[r];
      end
      case (stage)
        2'd0:    t = (b & c) | (~b & d);
        2'd2:    t = (b & c) | (b & d) | (c & d);
        default: t = b ^ c ^ d;
      endcase
      t = rotl(a, 5) + t + e + K_CONST[stage] + w;
      e = d; d = c; c = rotl(b, 30); b = a; a = t;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
    for (int i = 0; i < WIN; i++) sched[i] = '0;
  endfunction

  function automatic void sha1_clear();
    for (int i = 0; i < WORDS; i++) chain[i] = H_INIT[i];
    for (int i = 0; i < WIN; i++) sched[i] = '0;
    fill = '0;
    bit_len = '0;
  endfunction

  function automatic void sha1_put(logic [7:0] b);
    int sh;
    sh = (3 - fill[1:0]) * 8;
    sched[fill[5:2]] = (sched[fill[5:2]] & ~(32'hff << sh)) | (word_t'(b) << sh);
    fill = fill + 6'd1;
    if (fill == 0) sha1_compress();
  endfunction

  function automatic void sha1_absorb(in_item_t it);
    out_item_t o;
    if (it.has_byte) begin
      bit_len += 64'd8;
      sha1_put(it.msg_byte);
    end
    if (!it.end_of_message) return;
    sha1_put(PAD_BYTE);
    if (fill > 56) while (fill != 0) sha1_put(8'h00);
    while (fill < 56) sha1_put(8'h00);
    sched[14] = bit_len[63:32];
    sched[15] = bit_len[31:0];
    fill = '0;
    sha1_compress();
    for (int k = 0; k < WORDS; k++) begin
      o.digest_word = chain[k];
      o.word_index = 3'(k);
      o.last_word = (k == WORDS - 1);
      digest_queue.push_back(o);
    end
    sha1_clear();
  endfunction

  task automatic add_message(int len, bit empty_tail, bit with_noise);
    in_item_t it;
    for (int i = 0; i < len; i++) begin
      if (with_noise && $urandom_range(0, 9) == 0) begin
        it.msg_byte = 8'($urandom);
        it.has_byte = 1'b0;
        it.end_of_message = 1'b0;
        pending_items.push_back(it);
      end
      it.msg_byte = 8'($urandom);
      it.has_byte = 1'b1;
      it.end_of_message = !empty_tail && (i == len - 1);
      pending_items.push_back(it);
    end
    if (empty_tail || len == 0) begin
      it.msg_byte = 8'($urandom);
      it.has_byte = 1'b0;
      it.end_of_message = 1'b1;
      pending_items.push_back(it);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) sha1_absorb(in_ch.data);
      if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.data <= pending_items.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor and receiver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (digest_queue.size() == 0) begin
          $display("%0t: unexpected digest item %h", $time, out_ch.data);
          errors <= errors + 1;
        end else begin
          out_item_t exp_item;
          exp_item = digest_queue.pop_front();
          if (exp_item !== out_ch.data) begin
            $display("%0t: mismatch expected word %h idx %0d last %b, got word %h idx %0d last %b",
                     $time, exp_item.digest_word, exp_item.word_index, exp_item.last_word,
                     out_ch.data.digest_word, out_ch.data.word_index, out_ch.data.last_word);
            errors <= errors + 1;
          end
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    in_item_t it;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    sha1_clear();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: idle item, empty message, one byte extremes, empty-tail message
    it = '{msg_byte: 8'hff, has_byte: 1'b0, end_of_message: 1'b0};
    pending_items.push_back(it);
    add_message(0, 1'b1, 1'b0);
    it = '{msg_byte: 8'h00, has_byte: 1'b1, end_of_message: 1'b1};
    pending_items.push_back(it);
    it = '{msg_byte: 8'hff, has_byte: 1'b1, end_of_message: 1'b1};
    pending_items.push_back(it);
    add_message(3, 1'b1, 1'b0);

    // length boundaries around the one and two block padding cases
    add_message(55, 1'b0, 1'b0);
    add_message(56, 1'b0, 1'b0);
    // pressure: long receiver stall while a message streams in
    hold_off = 400;
    add_message(5, 1'b0, 1'b0);
    add_message(2, 1'b0, 1'b0);

    for (int phase = 0; phase < 3; phase++) begin
      wait (pending_items.size() == 0);
      send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 60 : 0;
      recv_idle_pct = (phase == 0) ? 60 : (phase == 1) ? 37 : 0;
      for (int m = 0; m < 2; m++) begin
        int len;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(57, 70) : $urandom_range(0, 8);
        add_message(len, $urandom_range(0, 3) == 0, 1'b1);
      end
    end
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done && pending_items.size() == 0 && !in_ch.valid
          && digest_queue.size() == 0);
    repeat (300) @(posedge clk);
    if (errors == 0 && digest_queue.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

endmodule
